>>> sv/srr_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Field widths, result codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int SEQ_NUM_W  = 16;
    localparam int PAYLOAD_W  = 32;
    localparam int WIN_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd4;

    // Register index taken from the word address bit of paddr.
    localparam logic CFG_IDX_WINDOW = 1'b0;

    // Result kinds.
    localparam logic RES_DELIVER = 1'b0;
    localparam logic RES_ACK     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_CLASS,
        ST_DRAIN_RD,
        ST_DELIVER,
        ST_ACK
    } srr_state_t;

endpackage

>>> sv/srr_in_if.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver input channel
// Valid/ready channel carrying one arriving packet per item.
// ----------------------------------------------------------------------------
interface srr_in_if;
    import srr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SEQ_NUM_W-1:0] seq_num;
    logic [PAYLOAD_W-1:0] payload_ref;

    modport source (output valid, output seq_num, output payload_ref, input ready);
    modport sink   (input valid, input seq_num, input payload_ref, output ready);
endinterface

>>> sv/srr_out_if.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver output channel
// Valid/ready channel carrying one delivery or one ACK per item.
// ----------------------------------------------------------------------------
interface srr_out_if;
    import srr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 res_kind;
    logic [SEQ_NUM_W-1:0] out_seq;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 dup_flag;
    logic                 last_flag;

    modport source (output valid, output res_kind, output out_seq, output out_payload,
                    output dup_flag, output last_flag, input ready);
    modport sink   (input valid, input res_kind, input out_seq, input out_payload,
                    input dup_flag, input last_flag, output ready);
endinterface

>>> sv/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// Selective-repeat ARQ receiver
// Buffers packets inside the receive window, delivers them upward in order
// and acknowledges every packet that falls inside or just behind the window.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Handshake            Contents
//  in_ch     sink    valid/ready          seq_num, payload_ref
//  out_ch    source  valid/ready          res_kind, out_seq, out_payload,
//                                         dup_flag, last_flag
//  APB       slave   psel/penable/pready  receive window at byte address 0
//
// A packet is taken in ST_IDLE, its offset from the receive base is formed
// in ST_OFFSET and classified in ST_CLASS, all through one shared subtractor.
// A packet outside the window then returns to ST_IDLE and an ACK-only packet
// goes to ST_ACK; for a packet at the base, each delivery reads the payload
// buffer in ST_DRAIN_RD (registered read port) and presents the item in
// ST_DELIVER, before the ACK. Stalls on out_ch simply hold the current item;
// in_ch is not ready until the last result of a packet has gone.
// rst_n clears the base, the ring head and the valid marks and returns the
// window register to four; the payload buffer has no reset and is read only
// where valid.
//
module selective_repeat_receiver #(
    parameter int BUF_DEPTH = 32,
    parameter int SEQ_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    srr_in_if.sink                      in_ch,
    srr_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [srr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [srr_pkg::APB_DATA_W-1:0] prdata,
    output logic                        pready
);
    import srr_pkg::*;

    localparam int HEAD_W = $clog2(BUF_DEPTH);
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    // Half the sequence space, saturated at a value above any window setting.
    localparam int HALF   = (SEQ_BITS - 1 > WIN_W) ? (1 << WIN_W) : (1 << (SEQ_BITS - 1));
    localparam int WMAX   = (BUF_DEPTH < HALF) ? BUF_DEPTH : HALF;

    // Control state.
    srr_state_t             state_reg, state_next;
    logic [WIN_W-1:0]       rx_window_reg;
    logic [SEQ_BITS-1:0]    base_reg, base_next;
    logic [HEAD_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [BUF_DEPTH-1:0]   slot_valid_reg, slot_valid_next;

    // Working registers for the packet in hand.
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;
    logic [PAYLOAD_W-1:0]   pay_reg, pay_next;
    logic [SEQ_BITS-1:0]    off_reg, off_next;
    logic                   dup_reg, dup_next;
    logic [PAYLOAD_W-1:0]   rd_data_reg;

    // Payload ring buffer.
    logic [PAYLOAD_W-1:0]   slot_payload_mem [BUF_DEPTH];
    logic                   mem_we;
    logic                   mem_re;
    logic [HEAD_W-1:0]      mem_waddr;

    logic                   in_accept;
    logic                   cfg_write;
    logic [SEQ_BITS+SEQ_NUM_W-1:0] seq_wide;
    logic [SEQ_BITS-1:0]    seq_in;
    logic [SEQ_NUM_W+SEQ_BITS-1:0] base_wide;
    logic [SEQ_NUM_W+SEQ_BITS-1:0] ack_wide;
    logic [WIN_W-1:0]       win_eff;
    logic [SEQ_BITS-1:0]    sub_a, sub_b, sub_res;
    logic [HEAD_W:0]        slot_sum;
    logic [HEAD_W-1:0]      slot_idx;
    logic [HEAD_W-1:0]      head_inc;
    logic                   is_base, is_ahead, is_behind;
    logic                   drain_more;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Only the low SEQ_BITS of the incoming number take part.
    assign seq_wide = {{SEQ_BITS{1'b0}}, in_ch.seq_num};
    assign seq_in   = seq_wide[SEQ_BITS-1:0];
    assign base_wide = {{SEQ_NUM_W{1'b0}}, base_reg};
    assign ack_wide  = {{SEQ_NUM_W{1'b0}}, seq_reg};

    // Window clamped to at least one and to the buffer and half-space limits.
    always_comb
    begin
        win_eff = rx_window_reg;
        if (rx_window_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (rx_window_reg > WIN_W'(WMAX))
        begin
            win_eff = WIN_W'(WMAX);
        end
    end

    // The shared subtractor: offset from the base first, then its negation
    // for the test against the stretch behind the base.
    always_comb
    begin
        case (state_reg)
            ST_OFFSET:
            begin
                sub_a = seq_reg;
                sub_b = base_reg;
            end
            default:
            begin
                sub_a = '0;
                sub_b = off_reg;
            end
        endcase
    end
    assign sub_res = sub_a - sub_b;

    assign is_base   = (off_reg == '0);
    assign is_ahead  = !is_base && (off_reg < SEQ_BITS'(win_eff));
    assign is_behind = !is_base && (sub_res <= SEQ_BITS'(win_eff));

    // Ring slot for an offset inside the window; the sum stays below twice
    // the depth, so one conditional subtract wraps it.
    assign slot_sum = {1'b0, head_reg} + (HEAD_W + 1)'(off_reg);
    assign slot_idx = (slot_sum >= (HEAD_W + 1)'(BUF_DEPTH))
                      ? HEAD_W'(slot_sum - (HEAD_W + 1)'(BUF_DEPTH))
                      : HEAD_W'(slot_sum);
    assign head_inc = (head_reg == HEAD_W'(BUF_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign drain_more = (count_reg < CNT_W'(BUF_DEPTH)) && slot_valid_reg[head_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET:
            begin
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (is_base)
                begin
                    state_next = ST_DRAIN_RD;
                end
                else if (is_ahead || is_behind)
                begin
                    state_next = ST_ACK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_RD:
            begin
                state_next = drain_more ? ST_DELIVER : ST_ACK;
            end
            ST_DELIVER:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_DRAIN_RD;
                end
            end
            ST_ACK:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and buffer control.
    always_comb
    begin
        base_next       = base_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        slot_valid_next = slot_valid_reg;
        seq_next        = seq_reg;
        pay_next        = pay_reg;
        off_next        = off_reg;
        dup_next        = dup_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    seq_next = seq_in;
                    pay_next = in_ch.payload_ref;
                end
            end
            ST_OFFSET:
            begin
                off_next = sub_res;
            end
            ST_CLASS:
            begin
                if (is_base)
                begin
                    mem_we                    = 1'b1;
                    slot_valid_next[head_reg] = 1'b1;
                    dup_next                  = 1'b0;
                    count_next                = '0;
                end
                else if (is_ahead)
                begin
                    mem_we                    = 1'b1;
                    mem_waddr                 = slot_idx;
                    slot_valid_next[slot_idx] = 1'b1;
                    dup_next                  = slot_valid_reg[slot_idx];
                end
                else
                begin
                    dup_next = 1'b1;
                end
            end
            ST_DRAIN_RD:
            begin
                mem_re = 1'b1;
            end
            ST_DELIVER:
            begin
                if (out_ch.ready)
                begin
                    slot_valid_next[head_reg] = 1'b0;
                    base_next                 = base_reg + 1'b1;
                    head_next                 = head_inc;
                    count_next                = count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Channel outputs.
    always_comb
    begin
        in_ch.ready        = 1'b0;
        out_ch.valid       = 1'b0;
        out_ch.res_kind    = RES_ACK;
        out_ch.out_seq     = ack_wide[SEQ_NUM_W-1:0];
        out_ch.out_payload = '0;
        out_ch.dup_flag    = 1'b0;
        out_ch.last_flag   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_DELIVER:
            begin
                out_ch.valid       = 1'b1;
                out_ch.res_kind    = RES_DELIVER;
                out_ch.out_seq     = base_wide[SEQ_NUM_W-1:0];
                out_ch.out_payload = rd_data_reg;
            end
            ST_ACK:
            begin
                out_ch.valid     = 1'b1;
                out_ch.dup_flag  = dup_reg;
                out_ch.last_flag = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration port: always ready, reads return the window register or zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_WINDOW)
                    ? {{(APB_DATA_W - WIN_W){1'b0}}, rx_window_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rx_window_reg   <= WIN_RESET;
            base_reg        <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            slot_valid_reg  <= '0;
            dup_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            slot_valid_reg <= slot_valid_next;
            dup_reg        <= dup_next;
            if (cfg_write && (paddr[2] == CFG_IDX_WINDOW))
            begin
                rx_window_reg <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        pay_reg <= pay_next;
        off_reg <= off_next;
    end

    // Payload buffer with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_payload_mem[mem_waddr] <= pay_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_payload_mem[head_reg];
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Streams packets at, ahead of, behind and outside the receive window into
// the receiver, predicts every delivery and ACK from an internal copy of the
// receive state, and checks each result item field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import srr_pkg::*;

    localparam int BUF_DEPTH = 32;
    localparam int SEQ_BITS  = 16;
    localparam int SEQ_SPACE = 1 << SEQ_BITS;

    // Register i sits at byte address 4*i.
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = APB_ADDR_W'(4 * int'(CFG_IDX_WINDOW));

    // The longest correct silence is the deliberate output hold plus a short
    // burst, so a far longer quiet stretch can only mean a hang.
    localparam int STALL_LIMIT      = 2000;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int QUIET_CYCLES     = 12;
    localparam int PHASE_TARGET     = 8;
    localparam int NUM_PHASES       = 7;

    typedef struct packed {
        logic [SEQ_NUM_W-1:0] seq;
        logic [PAYLOAD_W-1:0] payload;
    } packet_t;

    typedef struct packed {
        logic                 kind;
        logic [SEQ_NUM_W-1:0] seq;
        logic [PAYLOAD_W-1:0] payload;
        logic                 dup;
        logic                 last;
    } result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    srr_in_if  in_ch ();
    srr_out_if out_ch ();

    selective_repeat_receiver #(
        .BUF_DEPTH (BUF_DEPTH),
        .SEQ_BITS  (SEQ_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Packets waiting to be offered, and the results they are owed.
    packet_t packet_queue[$];
    result_t due_results[$];

    // Shadow of the receiver: base, ring of slots and the window register.
    logic [SEQ_NUM_W-1:0] rx_base;
    logic [PAYLOAD_W-1:0] ring_pay [BUF_DEPTH];
    logic                 ring_valid [BUF_DEPTH];
    int                   ring_head;
    logic [WIN_W-1:0]     win_reg;

    int  error_count;
    int  accepted_count;
    int  checked_count;
    int  settings_count;
    int  max_drain;
    bit  idle_en;
    int  src_gap;
    int  sink_gap;
    int  long_hold_left;
    bit  long_hold_done;
    packet_t next_pkt;
    result_t seen_res;
    result_t want_res;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The window is clamped to at least one packet, to the ring depth and to
    // half of the sequence space.
    function automatic int eff_window(input logic [WIN_W-1:0] ws);
        int w;
        w = int'(ws);
        if (w < 1)
            w = 1;
        if (w > BUF_DEPTH)
            w = BUF_DEPTH;
        if (w > SEQ_SPACE / 2)
            w = SEQ_SPACE / 2;
        return w;
    endfunction

    // Applies one accepted packet to the shadow state and queues the
    // deliveries and the ACK that it owes.
    task automatic model_receive(input logic [SEQ_NUM_W-1:0] seq,
                                 input logic [PAYLOAD_W-1:0] pay);
        logic [SEQ_NUM_W-1:0] off;
        int w;
        int slot;
        int drained;
        w   = eff_window(win_reg);
        off = seq - rx_base;
        if (off == '0)
        begin
            // At the base: store it, then drain every consecutive slot.
            ring_pay[ring_head]   = pay;
            ring_valid[ring_head] = 1'b1;
            drained = 0;
            while (drained < BUF_DEPTH && ring_valid[ring_head])
            begin
                due_results.push_back('{RES_DELIVER, rx_base, ring_pay[ring_head],
                                        1'b0, 1'b0});
                ring_valid[ring_head] = 1'b0;
                rx_base   = rx_base + 1'b1;
                ring_head = (ring_head + 1) % BUF_DEPTH;
                drained++;
            end
            if (drained > max_drain)
                max_drain = drained;
            due_results.push_back('{RES_ACK, seq, '0, 1'b0, 1'b1});
        end
        else if (int'(off) < w)
        begin
            // Ahead of the base: buffer, overwriting a packet already held.
            slot = (ring_head + int'(off)) % BUF_DEPTH;
            due_results.push_back('{RES_ACK, seq, '0, ring_valid[slot], 1'b1});
            ring_pay[slot]   = pay;
            ring_valid[slot] = 1'b1;
        end
        else if (int'(off) >= SEQ_SPACE - w)
        begin
            // Behind the base: already delivered, so always a duplicate.
            due_results.push_back('{RES_ACK, seq, '0, 1'b1, 1'b1});
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Packet source. An item stays on the channel until it is taken; only
    // then may a random gap open before the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                model_receive(in_ch.seq_num, in_ch.payload_ref);
                accepted_count++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (idle_en && packet_queue.size() > 0 && $urandom_range(0, 4) == 0)
                begin
                    src_gap = $urandom_range(0, 3);
                    in_ch.valid <= 1'b0;
                end
                else if (packet_queue.size() > 0)
                begin
                    next_pkt = packet_queue.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.seq_num     <= next_pkt.seq;
                    in_ch.payload_ref <= next_pkt.payload;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
        else
        begin
            in_ch.valid       <= 1'b0;
            in_ch.seq_num     <= '0;
            in_ch.payload_ref <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink and checker. Once enough results have come, ready is held
    // low for a long stretch so that the receiver backs up into its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen_res = '{out_ch.res_kind, out_ch.out_seq, out_ch.out_payload,
                             out_ch.dup_flag, out_ch.last_flag};
                if (due_results.size() == 0)
                begin
                    $error("unexpected result item: res_kind %0d out_seq 0x%0h",
                           seen_res.kind, seen_res.seq);
                    error_count++;
                end
                else
                begin
                    want_res = due_results.pop_front();
                    check_field("res_kind", 32'(want_res.kind), 32'(seen_res.kind));
                    check_field("out_seq", 32'(want_res.seq), 32'(seen_res.seq));
                    check_field("out_payload", want_res.payload, seen_res.payload);
                    check_field("dup_flag", 32'(want_res.dup), 32'(seen_res.dup));
                    check_field("last_flag", 32'(want_res.last), 32'(seen_res.last));
                end
                checked_count++;
            end

            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && checked_count >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
        else
        begin
            out_ch.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no item and no register access moves.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_packet(input logic [SEQ_NUM_W-1:0] seq,
                               input logic [PAYLOAD_W-1:0] pay);
        packet_queue.push_back('{seq, pay});
    endtask

    // Waits until every queued packet has been taken, so that the shadow base
    // is exact when the next batch is built from it.
    task automatic wait_sender_drained();
        while (packet_queue.size() > 0 || in_ch.valid)
            @(negedge clk);
    endtask

    // Waits until the receiver has nothing left to do. A packet outside the
    // window leaves no result behind, so a quiet stretch follows.
    task automatic wait_idle();
        wait_sender_drained();
        while (due_results.size() > 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // Writes the window register, then reads it back. The write lands at the
    // edge that closes the access cycle.
    task automatic write_window(input logic [WIN_W-1:0] ws);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= APB_DATA_W'(ws);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        win_reg = ws;
        settings_count++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(ws))
        begin
            $error("rx_window: expected 0x%0h, got 0x%0h", ws, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Offsets 0..k-1 from the base in shuffled order. With base_last set the
    // base packet comes last, so the whole run is buffered and then drained
    // in one go.
    task automatic queue_burst(input int k, input bit base_last);
        int offs [BUF_DEPTH];
        int j;
        int pick;
        int tmp;
        int lo;
        lo = base_last ? 1 : 0;
        for (j = 0; j < k; j++)
            offs[j] = j;
        for (j = k - 1; j > lo; j--)
        begin
            pick = $urandom_range(lo, j);
            tmp = offs[j];
            offs[j] = offs[pick];
            offs[pick] = tmp;
        end
        for (j = lo; j < k; j++)
            push_packet(rx_base + SEQ_NUM_W'(offs[j]), $urandom);
        if (base_last)
            push_packet(rx_base, $urandom);
    endtask

    // One batch of random traffic around the base. Most of it is well formed;
    // the rest is noise that the receiver mostly drops, which does not count.
    task automatic queue_random_batch(output int counted);
        int w;
        int pick;
        int k;
        int j;
        w = eff_window(win_reg);
        pick = $urandom_range(0, 99);
        counted = 0;
        if (pick < 40)
        begin
            k = $urandom_range(1, w);
            queue_burst(k, $urandom_range(0, 1));
            counted = k;
        end
        else if (pick < 60 && w > 1)
        begin
            k = $urandom_range(1, 3);
            for (j = 0; j < k; j++)
                push_packet(rx_base + SEQ_NUM_W'($urandom_range(1, w - 1)), $urandom);
            counted = k;
        end
        else if (pick < 72)
        begin
            push_packet(rx_base - SEQ_NUM_W'($urandom_range(1, w)), $urandom);
            counted = 1;
        end
        else if (pick < 85)
        begin
            push_packet(rx_base, $urandom);
            counted = 1;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: push_packet(SEQ_NUM_W'($urandom), $urandom);
                1: push_packet(rx_base + SEQ_NUM_W'(w), $urandom);
                default: push_packet(rx_base - SEQ_NUM_W'(w + 1), $urandom);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int phase;
        int counted;
        int batch;
        logic [WIN_W-1:0] setting;

        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        rx_base   = '0;
        ring_head = 0;
        win_reg   = WIN_RESET;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            ring_valid[i] = 1'b0;
            ring_pay[i]   = '0;
        end
        error_count    = 0;
        accepted_count = 0;
        checked_count  = 0;
        settings_count = 0;
        max_drain      = 0;
        idle_en        = 1'b1;
        src_gap        = 0;
        sink_gap       = 0;
        long_hold_left = 0;
        long_hold_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset window of four. The base starts at zero,
        // so the sequence numbers below are worked out by hand.
        push_packet(16'h0000, 32'h0000_0000);   // at the base, drains itself
        push_packet(16'hFFFF, 32'hFFFF_FFFF);   // behind, across the wrap
        push_packet(16'h0003, 32'hFFFF_FFFF);   // ahead, buffered
        push_packet(16'h0003, 32'hA5A5_A5A5);   // ahead again: duplicate, overwrites
        push_packet(16'h0004, 32'h5A5A_5A5A);   // last slot of the window
        push_packet(16'h0005, 32'h1111_1111);   // just past the window: dropped
        push_packet(16'h8001, 32'h2222_2222);   // far away: dropped
        push_packet(16'h0001, 32'h0000_0001);   // at the base, gap follows
        push_packet(16'h0002, 32'h1234_5678);   // at the base, drains three
        push_packet(16'h0002, 32'h3333_3333);   // behind, duplicate
        push_packet(16'h0001, 32'h4444_4444);   // oldest number still behind
        push_packet(16'h0000, 32'h5555_5555);   // one further back: dropped
        push_packet(16'h0008, 32'h6666_6666);   // ahead at the window edge
        wait_idle();

        // Window shrink: marks buffered under a wide window survive a
        // narrower one and are drained once the base reaches them.
        write_window(6'd32);
        push_packet(rx_base + 16'd2, $urandom);
        push_packet(rx_base + 16'd5, $urandom);
        wait_idle();
        write_window(6'd2);
        push_packet(rx_base + 16'd5, $urandom);  // held, but now outside: dropped
        push_packet(rx_base + 16'd1, $urandom);
        push_packet(rx_base, $urandom);
        wait_idle();

        // Random part. Each phase runs under one window setting, among them
        // the extremes and values that the clamp has to pull back into range.
        // The last phase runs with no idling on either side.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: setting = 6'd1;
                1: setting = 6'd32;
                2: setting = 6'd0;
                3: setting = 6'd63;
                4: setting = 6'd9;
                5: setting = WIN_W'($urandom_range(2, 31));
                default: setting = WIN_RESET;
            endcase
            if (phase == NUM_PHASES - 1)
                idle_en = 1'b0;
            wait_idle();
            write_window(setting);

            // With the widest window, buffer every slot and then send the
            // base, which drains the entire ring behind a single ACK.
            batch = 0;
            if (eff_window(win_reg) == BUF_DEPTH)
            begin
                queue_burst(BUF_DEPTH, 1'b1);
                batch = BUF_DEPTH;
            end
            while (batch < PHASE_TARGET)
            begin
                wait_sender_drained();
                queue_random_batch(counted);
                batch += counted;
            end
        end

        wait_idle();
        repeat (QUIET_CYCLES) @(negedge clk);

        $display("Summary: %0d packets taken, %0d result items checked, %0d window writes.",
                 accepted_count, checked_count, settings_count);
        $display("Summary: longest in-order drain %0d deliveries, %0d results still owed.",
                 max_drain, due_results.size());
        if (error_count == 0 && due_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/srr_pkg.sv
sv/srr_in_if.sv
sv/srr_out_if.sv
sv/selective_repeat_receiver.sv
tb/testbench.sv
